/* sv/hbfd_pkg.sv */
// Package for the HTTP body framing decoder.
// Holds field widths, phase codes, register indexes and the hex digit decoder.
// Has no dependencies.
package hbfd_pkg;

	localparam int BYTE_W = 8;
	localparam int CONTENT_LENGTH_W = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BODY_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTENT_LENGTH = 1'd1;

	localparam logic BODY_MODE_CHUNKED = 1'b0;
	localparam logic BODY_MODE_LENGTH = 1'b1;

	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_START = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SIZE_LF = 3'd1;
	localparam logic [PHASE_W-1:0] PH_CDATA = 3'd2;
	localparam logic [PHASE_W-1:0] PH_CSKIP = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ENDSKIP = 3'd4;
	localparam logic [PHASE_W-1:0] PH_LDATA = 3'd5;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
	localparam logic [1:0] CRLF_LEN = 2'd2;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_digit_t r;
		r.ok = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

/* sv/hbfd_raw_if.sv */
// Channel for raw body bytes entering the decoder.
// Depends on hbfd_pkg for the byte width.
interface hbfd_raw_if import hbfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

/* sv/hbfd_result_if.sv */
// Channel for decoded result items leaving the decoder.
// Depends on hbfd_pkg for the byte width.
interface hbfd_result_if import hbfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              payload_valid;
	logic              body_end;

	modport source (output valid, output out_byte, output payload_valid, output body_end,
		input ready);
	modport sink (input valid, input out_byte, input payload_valid, input body_end,
		output ready);
endinterface

/* sv/http_body_framing_decoder.sv */
// HTTP body framing decoder: chunked transfer decoding or fixed content length.
// Each accepted byte's result item is registered in the output register.
// One item per cycle unless payload.ready is low; output is refilled while being taken.
// Reset (arst_n low, asynchronous) returns to body start in chunked mode, length one.
// Depends on hbfd_pkg, hbfd_raw_if and hbfd_result_if.
module http_body_framing_decoder import hbfd_pkg::*; #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hbfd_raw_if.sink              raw,
	hbfd_result_if.source         payload,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LB = LENGTH_BITS;
	localparam int XW = (LB > CONTENT_LENGTH_W) ? LB : CONTENT_LENGTH_W;
	localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
	localparam logic [LB-1:0] LEN_ONE = LB'(1);

	logic                        body_mode_q;
	logic [CONTENT_LENGTH_W-1:0] content_length_q;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [LB-1:0]      bytes_left_q, bytes_left_d;
	logic [LB-1:0]      size_accum_q, size_accum_d;
	logic               closed_q, closed_d;
	logic [1:0]         skip_q, skip_d;

	logic               out_vld_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_pv_q, out_end_q;
	logic               pv_d, end_d;

	logic               accept;
	hex_digit_t         hd;
	logic [LB+3:0]      acc_ext;
	logic [LB-1:0]      acc_next;
	logic [XW-1:0]      cl_x;
	logic [LB-1:0]      len_n;
	logic [LB-1:0]      left_dec;

	assign raw.ready = !out_vld_q || payload.ready;
	assign accept = raw.valid && raw.ready;

	assign hd = hex_decode(raw.in_byte);
	assign acc_ext = {size_accum_q, 4'b0000} + {{LB{1'b0}}, hd.val};
	assign acc_next = (acc_ext[LB+3:LB] != 4'd0) ? LEN_MAX : acc_ext[LB-1:0];
	assign cl_x = XW'(content_length_q);
	assign left_dec = bytes_left_q - LEN_ONE;

	always_comb begin
		if (cl_x > XW'(LEN_MAX)) begin
			len_n = LEN_MAX;
		end else if (cl_x == '0) begin
			len_n = LEN_ONE;
		end else begin
			len_n = cl_x[LB-1:0];
		end
	end

	always_comb begin
		phase_d = phase_q;
		bytes_left_d = bytes_left_q;
		size_accum_d = size_accum_q;
		closed_d = closed_q;
		skip_d = skip_q;
		pv_d = 1'b0;
		end_d = 1'b0;
		case (phase_q)
			PH_SIZE_LF: begin
				if (size_accum_q == '0) begin
					phase_d = PH_ENDSKIP;
					skip_d = CRLF_LEN;
				end else begin
					bytes_left_d = size_accum_q;
					phase_d = PH_CDATA;
				end
				size_accum_d = '0;
				closed_d = 1'b0;
			end
			PH_CDATA: begin
				pv_d = 1'b1;
				bytes_left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_CSKIP;
					skip_d = CRLF_LEN;
				end
			end
			PH_CSKIP: begin
				skip_d = skip_q - 2'd1;
				if (skip_q == 2'd1) begin
					phase_d = PH_START;
				end
			end
			PH_ENDSKIP: begin
				skip_d = skip_q - 2'd1;
				if (skip_q == 2'd1) begin
					phase_d = PH_START;
					end_d = 1'b1;
				end
			end
			PH_LDATA: begin
				pv_d = 1'b1;
				bytes_left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_START;
					end_d = 1'b1;
				end
			end
			default: begin
				phase_d = PH_START;
				if (size_accum_q == '0 && !closed_q && body_mode_q == BODY_MODE_LENGTH) begin
					pv_d = 1'b1;
					bytes_left_d = len_n - LEN_ONE;
					if (len_n == LEN_ONE) begin
						end_d = 1'b1;
					end else begin
						phase_d = PH_LDATA;
					end
				end else if (raw.in_byte == CHAR_CR) begin
					phase_d = PH_SIZE_LF;
				end else if (!closed_q && hd.ok) begin
					size_accum_d = acc_next;
				end else begin
					closed_d = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_mode_q <= BODY_MODE_CHUNKED;
			content_length_q <= CONTENT_LENGTH_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BODY_MODE: body_mode_q <= cfg_data[0];
				REG_CONTENT_LENGTH: content_length_q <= cfg_data[CONTENT_LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			bytes_left_q <= '0;
			size_accum_q <= '0;
			closed_q <= 1'b0;
			skip_q <= 2'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			bytes_left_q <= bytes_left_d;
			size_accum_q <= size_accum_d;
			closed_q <= closed_d;
			skip_q <= skip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (payload.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= pv_d ? raw.in_byte : '0;
			out_pv_q <= pv_d;
			out_end_q <= end_d;
		end
	end

	assign payload.valid = out_vld_q;
	assign payload.out_byte = out_byte_q;
	assign payload.payload_valid = out_pv_q;
	assign payload.body_end = out_end_q;

	// Data phases always have at least one byte left to pass.
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CDATA || phase_q == PH_LDATA) |-> bytes_left_q != '0)
		else $error("data phase with no bytes left");

	// Skip phases always have a byte still to drop.
	a_skip_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CSKIP || phase_q == PH_ENDSKIP) |-> skip_q != 2'd0)
		else $error("skip phase with zero skip count");

	// A chunk data byte never completes the body.
	a_cdata_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_CDATA) |=> (out_pv_q && !out_end_q))
		else $error("chunk data byte flagged as body end");

	// The last length-mode byte ends the body and returns to body start.
	a_ldata_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_LDATA && bytes_left_q == LEN_ONE)
		|=> (out_end_q && phase_q == PH_START))
		else $error("last length-mode byte did not end the body");

endmodule
